// File: hw/rtl/pspd_pkg.sv
// ----------------------------------------------------------------------------
// pspd_pkg: shared types and constants
// Microcode word, datapath control bundle, register indexes and fixed
// field widths of the speed-to-duty PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package pspd_pkg;

  localparam int GAIN_W   = 16;
  localparam int SCALE_W  = 20;
  localparam int DUTY_W   = 16;
  localparam int CTRL_W   = 32;
  localparam int CORR_W   = 34;
  localparam int MUL_B_W  = SCALE_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = SCALE_W;
  localparam int STEP_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd7;

  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_P   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_I   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_D   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ACC_D   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CTRL    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_S   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CORR    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_MUL_T   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DONE    = 4'd9;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_DONE
  } pspd_seq_t;

  typedef enum logic [2:0] {
    MA_NONE,
    MA_ERR,
    MA_SUM,
    MA_DERIV,
    MA_CTRL,
    MA_CORR
  } pspd_mula_t;

  typedef enum logic [2:0] {
    MB_GP,
    MB_GI,
    MB_GD,
    MB_SCALE,
    MB_TRIM
  } pspd_mulb_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } pspd_acc_t;

  typedef struct packed {
    pspd_seq_t  seq;
    pspd_mula_t mul_a;
    pspd_mulb_t mul_b;
    pspd_acc_t  acc_op;
    logic       ld_ctrl;
    logic       ld_corr;
  } pspd_uword_t;

  typedef struct packed {
    pspd_uword_t uw;
    logic        in_fire;
    logic        out_load;
  } pspd_ctl_t;

  function automatic pspd_uword_t pspd_ucode(input logic [STEP_W-1:0] step);
    pspd_uword_t w;
    w = '{seq: SEQ_NEXT, mul_a: MA_NONE, mul_b: MB_GP, acc_op: ACC_HOLD,
          ld_ctrl: 1'b0, ld_corr: 1'b0};
    unique case (step)
      STEP_IDLE:  w.seq = SEQ_WAIT_IN;
      STEP_MUL_P: begin
        w.mul_a = MA_ERR;
        w.mul_b = MB_GP;
      end
      STEP_MUL_I: begin
        w.mul_a  = MA_SUM;
        w.mul_b  = MB_GI;
        w.acc_op = ACC_LOAD;
      end
      STEP_MUL_D: begin
        w.mul_a  = MA_DERIV;
        w.mul_b  = MB_GD;
        w.acc_op = ACC_ADD;
      end
      STEP_ACC_D: w.acc_op = ACC_ADD;
      STEP_CTRL:  w.ld_ctrl = 1'b1;
      STEP_MUL_S: begin
        w.mul_a = MA_CTRL;
        w.mul_b = MB_SCALE;
      end
      STEP_CORR:  w.ld_corr = 1'b1;
      STEP_MUL_T: begin
        w.mul_a = MA_CORR;
        w.mul_b = MB_TRIM;
      end
      STEP_DONE:  w.seq = SEQ_DONE;
      default:    w.seq = SEQ_NEXT;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pid_speed_to_pwm_duty.sv
// ----------------------------------------------------------------------------
// pid_speed_to_pwm_duty: PID wheel speed to PWM duty
// One measured speed per item in, one duty level, control value and clamp
// flag out. Integral and previous error persist across items.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   measured_speed
//   out      out_valid / out_ready duty_level, control_value, clamped
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A result is loaded into the output register once its item has run through
// a ten-step microcode program (idle plus nine working steps) that drives
// one shared 34x21 multiplier through five products plus accumulate, saturate
// and clamp steps. The next item is accepted the cycle after the result is
// loaded, even while it waits, never while an item is still in the program.
// Reset (synchronous) clears integral, previous error, step and out_valid and
// sets config registers to defaults. A stalled output holds the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_speed_to_pwm_duty #(
  parameter int SPEED_BITS = 12,
  parameter int SUM_BITS   = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SPEED_BITS-1:0]              measured_speed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pspd_pkg::DUTY_W-1:0]        duty_level,
  output logic signed [pspd_pkg::CTRL_W-1:0] control_value,
  output logic                               clamped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pspd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pspd_pkg::*;

  pspd_ctl_t             ctl;
  logic [SPEED_BITS-1:0] speed_setpoint;
  logic [GAIN_W-1:0]     gain_p;
  logic [GAIN_W-1:0]     gain_i;
  logic [GAIN_W-1:0]     gain_d;
  logic [SCALE_W-1:0]    duty_scale;
  logic [DUTY_W-1:0]     base_duty;
  logic [GAIN_W-1:0]     trim_factor;
  logic [DUTY_W-1:0]     duty_top;

  pspd_cfg #(
    .SPEED_BITS (SPEED_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .speed_setpoint (speed_setpoint),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .duty_scale     (duty_scale),
    .base_duty      (base_duty),
    .trim_factor    (trim_factor),
    .duty_top       (duty_top)
  );

  pspd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  pspd_dp #(
    .SPEED_BITS (SPEED_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .measured_speed (measured_speed),
    .speed_setpoint (speed_setpoint),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .duty_scale     (duty_scale),
    .base_duty      (base_duty),
    .trim_factor    (trim_factor),
    .duty_top       (duty_top),
    .duty_level     (duty_level),
    .control_value  (control_value),
    .clamped        (clamped)
  );

endmodule

`default_nettype wire

// File: hw/rtl/pspd_cfg.sv
// ----------------------------------------------------------------------------
// pspd_cfg: configuration register file
// Holds setpoint, gains, scale, base, trim and top; one write per item.
// ----------------------------------------------------------------------------
`default_nettype none

module pspd_cfg #(
  parameter int SPEED_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pspd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [SPEED_BITS-1:0]               speed_setpoint,
  output logic [pspd_pkg::GAIN_W-1:0]         gain_p,
  output logic [pspd_pkg::GAIN_W-1:0]         gain_i,
  output logic [pspd_pkg::GAIN_W-1:0]         gain_d,
  output logic [pspd_pkg::SCALE_W-1:0]        duty_scale,
  output logic [pspd_pkg::DUTY_W-1:0]         base_duty,
  output logic [pspd_pkg::GAIN_W-1:0]         trim_factor,
  output logic [pspd_pkg::DUTY_W-1:0]         duty_top
);
  import pspd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_setpoint <= SPEED_BITS'(100);
      gain_p         <= GAIN_W'(2048);
      gain_i         <= GAIN_W'(819);
      gain_d         <= GAIN_W'(82);
      duty_scale     <= SCALE_W'(3543);
      base_duty      <= DUTY_W'(24000);
      trim_factor    <= GAIN_W'(16384);
      duty_top       <= DUTY_W'(50000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET: speed_setpoint <= cfg_data[SPEED_BITS-1:0];
        REG_GAIN_P: gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I: gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D: gain_d         <= cfg_data[GAIN_W-1:0];
        REG_SCALE:  duty_scale     <= cfg_data[SCALE_W-1:0];
        REG_BASE:   base_duty      <= cfg_data[DUTY_W-1:0];
        REG_TRIM:   trim_factor    <= cfg_data[GAIN_W-1:0];
        REG_TOP:    duty_top       <= cfg_data[DUTY_W-1:0];
        default:    ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pspd_seq.sv
// ----------------------------------------------------------------------------
// pspd_seq: microcode sequencer
// Step counter over the control-word table, input/output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pspd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pspd_pkg::pspd_ctl_t ctl
);
  import pspd_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;
  pspd_uword_t       uw;
  logic              in_fire;
  logic              out_load;

  assign uw = pspd_ucode(step);

  always_comb begin
    in_ready = 1'b0;
    in_fire  = 1'b0;
    out_load = 1'b0;
    unique case (uw.seq)
      SEQ_WAIT_IN: begin
        in_ready = 1'b1;
        in_fire  = in_valid;
      end
      SEQ_DONE:    out_load = !out_valid || out_ready;
      SEQ_NEXT:    ;
      default:     ;
    endcase
  end

  always_comb begin
    step_next = step;
    unique case (uw.seq)
      SEQ_WAIT_IN: if (in_valid) step_next = step + STEP_W'(1);
      SEQ_DONE:    if (!out_valid || out_ready) step_next = STEP_IDLE;
      SEQ_NEXT:    step_next = step + STEP_W'(1);
      default:     step_next = STEP_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign ctl = '{uw: uw, in_fire: in_fire, out_load: out_load};

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      out_valid <= 1'b0;
    end else begin
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pspd_dp.sv
// ----------------------------------------------------------------------------
// pspd_dp: PID datapath
// Error, integral and derivative registers, one shared multiplier,
// accumulator, saturation and duty clamp, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pspd_dp #(
  parameter int SPEED_BITS = 12,
  parameter int SUM_BITS   = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pspd_pkg::pspd_ctl_t                ctl,
  input  logic [SPEED_BITS-1:0]              measured_speed,
  input  logic [SPEED_BITS-1:0]              speed_setpoint,
  input  logic [pspd_pkg::GAIN_W-1:0]        gain_p,
  input  logic [pspd_pkg::GAIN_W-1:0]        gain_i,
  input  logic [pspd_pkg::GAIN_W-1:0]        gain_d,
  input  logic [pspd_pkg::SCALE_W-1:0]       duty_scale,
  input  logic [pspd_pkg::DUTY_W-1:0]        base_duty,
  input  logic [pspd_pkg::GAIN_W-1:0]        trim_factor,
  input  logic [pspd_pkg::DUTY_W-1:0]        duty_top,
  output logic [pspd_pkg::DUTY_W-1:0]        duty_level,
  output logic signed [pspd_pkg::CTRL_W-1:0] control_value,
  output logic                               clamped
);
  import pspd_pkg::*;

  localparam int E_W   = SPEED_BITS + 1;
  localparam int D_W   = SPEED_BITS + 2;
  localparam int SA_W  = ((SUM_BITS > E_W) ? SUM_BITS : E_W) + 1;
  localparam int A_W   = (SUM_BITS > CORR_W) ? SUM_BITS : CORR_W;
  localparam int P_W   = A_W + MUL_B_W;
  localparam int ACC_W = ((SUM_BITS > D_W) ? SUM_BITS : D_W) + GAIN_W + 3;

  localparam logic signed [SA_W-1:0] SUM_MAX =
    SA_W'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
  localparam logic signed [SA_W-1:0] SUM_MIN = -SUM_MAX - SA_W'(1);
  localparam logic signed [63:0] CTRL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] CTRL_MIN = -64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] CORR_LIM = 64'sh0000_0001_0000_0000;

  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [E_W-1:0]      last_error;
  logic signed [E_W-1:0]      err;
  logic signed [D_W-1:0]      deriv;
  logic signed [P_W-1:0]      prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [CTRL_W-1:0]   ctrl;
  logic signed [CORR_W-1:0]   corr;

  logic signed [E_W-1:0]      err_in;
  logic signed [D_W-1:0]      deriv_in;
  logic signed [SA_W-1:0]     sum_add;
  logic signed [SUM_BITS-1:0] error_sum_next;
  logic signed [A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]         mul_b_u;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [63:0]         acc_sh;
  logic signed [63:0]         prod_wide;
  logic signed [63:0]         corr_sh;
  logic signed [63:0]         duty_sum;
  logic signed [CTRL_W-1:0]   ctrl_next;
  logic signed [CORR_W-1:0]   corr_next;
  logic [DUTY_W-1:0]          duty_next;
  logic                       clamped_next;

  assign err_in   = $signed({1'b0, speed_setpoint}) - $signed({1'b0, measured_speed});
  assign deriv_in = D_W'(err_in) - D_W'(last_error);
  assign sum_add  = SA_W'(error_sum) + SA_W'(err_in);

  always_comb begin
    if (sum_add > SUM_MAX) begin
      error_sum_next = SUM_MAX[SUM_BITS-1:0];
    end else if (sum_add < SUM_MIN) begin
      error_sum_next = SUM_MIN[SUM_BITS-1:0];
    end else begin
      error_sum_next = sum_add[SUM_BITS-1:0];
    end
  end

  always_comb begin
    unique case (ctl.uw.mul_a)
      MA_ERR:   mul_a = A_W'(err);
      MA_SUM:   mul_a = A_W'(error_sum);
      MA_DERIV: mul_a = A_W'(deriv);
      MA_CTRL:  mul_a = A_W'(ctrl);
      MA_CORR:  mul_a = A_W'(corr);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uw.mul_b)
      MB_GP:    mul_b_u = MUL_B_W'(gain_p);
      MB_GI:    mul_b_u = MUL_B_W'(gain_i);
      MB_GD:    mul_b_u = MUL_B_W'(gain_d);
      MB_SCALE: mul_b_u = MUL_B_W'(duty_scale);
      MB_TRIM:  mul_b_u = MUL_B_W'(trim_factor);
      default:  mul_b_u = '0;
    endcase
  end

  assign mul_b = $signed(mul_b_u);

  assign acc_sh    = 64'(acc) >>> 12;
  assign prod_wide = 64'(prod);
  assign corr_sh   = prod_wide >>> 4;
  assign duty_sum  = (prod_wide >>> 14) + $signed(64'(base_duty));

  always_comb begin
    if (acc_sh > CTRL_MAX) begin
      ctrl_next = CTRL_MAX[CTRL_W-1:0];
    end else if (acc_sh < CTRL_MIN) begin
      ctrl_next = CTRL_MIN[CTRL_W-1:0];
    end else begin
      ctrl_next = acc_sh[CTRL_W-1:0];
    end
  end

  always_comb begin
    if (corr_sh > CORR_LIM) begin
      corr_next = CORR_LIM[CORR_W-1:0];
    end else if (corr_sh < -CORR_LIM) begin
      corr_next = CORR_W'(-CORR_LIM);
    end else begin
      corr_next = corr_sh[CORR_W-1:0];
    end
  end

  always_comb begin
    if (duty_sum < 64'sd0) begin
      duty_next    = '0;
      clamped_next = 1'b1;
    end else if (duty_sum > $signed(64'(duty_top))) begin
      duty_next    = duty_top;
      clamped_next = 1'b1;
    end else begin
      duty_next    = duty_sum[DUTY_W-1:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctl.in_fire) begin
      error_sum  <= error_sum_next;
      last_error <= err_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_fire) begin
      err   <= err_in;
      deriv <= deriv_in;
    end
    if (ctl.uw.mul_a != MA_NONE) begin
      prod <= mul_a * mul_b;
    end
    unique case (ctl.uw.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  ;
    endcase
    if (ctl.uw.ld_ctrl) begin
      ctrl <= ctrl_next;
    end
    if (ctl.uw.ld_corr) begin
      corr <= corr_next;
    end
    if (ctl.out_load) begin
      duty_level    <= duty_next;
      control_value <= ctrl;
      clamped       <= clamped_next;
    end
  end

endmodule

`default_nettype wire
